[rtl/lbr_pkg.sv]
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared types and constants for the bounded random number unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lbr_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic [DATA_W-1:0] SEED_RESET = 32'h000C_0DA1;

    typedef struct packed {
        logic load;
        logic step;
    } lbr_lfsr_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DRAW = 3'b010,
        ST_DONE = 3'b100
    } lbr_state_t;

endpackage

`default_nettype wire

[rtl/lfsr_bounded_random_unit.sv]
// ----------------------------------------------------------------------------
// lfsr_bounded_random_unit
// Uniform random value in 0..upper_bound from a 32-bit LFSR by rejection.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall, upper_bound): one transaction per
//   draw. in_stall is high from acceptance until the result is written to
//   the output register.
//   Result channel (out_valid / out_stall, drawn_value): one transaction per
//   request. The output register holds its value while out_stall is high,
//   and a new request is taken meanwhile; its result waits in the sequencer
//   until the register frees.
//   Seed channel (cfg_valid / cfg_ready, seed_value): reloads the LFSR;
//   ready only while no request is in progress.
//   Timing: each attempt draws max(1, bit length of upper_bound) bits, one
//   LFSR step per cycle; about two attempts on average. Throughput is set
//   by the single shared LFSR stepper.
//   Reset: seed and LFSR load 0xC0DA1, output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsr_bounded_random_unit
    import lbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [DATA_W-1:0]    upper_bound,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [DATA_W-1:0]         drawn_value,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [DATA_W-1:0]    seed_value
);

    logic [DATA_W-1:0] seed_reg;
    logic              seq_idle;
    logic              lfsr_step;
    logic              lfsr_bit;
    logic              cfg_take;
    lbr_lfsr_ctrl_t    lfsr_ctrl;

    assign cfg_ready      = seq_idle;
    assign cfg_take       = cfg_valid && cfg_ready;
    assign lfsr_ctrl.load = cfg_take;
    assign lfsr_ctrl.step = lfsr_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_take)
        begin
            seed_reg <= seed_value;
        end
    end

    lbr_lfsr u_lfsr (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lfsr_ctrl),
        .load_value (seed_value),
        .next_bit   (lfsr_bit)
    );

    lbr_draw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .upper_bound (upper_bound),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drawn_value (drawn_value),
        .lfsr_step   (lfsr_step),
        .lfsr_bit    (lfsr_bit),
        .idle        (seq_idle)
    );

    a_seed_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_take |=> (seed_reg == $past(seed_value)))
        else $error("seed register missed a write");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_ctrl.load |-> !lfsr_ctrl.step)
        else $error("seed load during a draw");

    a_stall_when_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> in_stall)
        else $error("request accepted while seed port blocked");

endmodule

`default_nettype wire

[rtl/lbr_lfsr.sv]
// ----------------------------------------------------------------------------
// lbr_lfsr
// 32-bit right-shifting LFSR, taps 31/6/4/2/1/0 fed into bit 31.
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_lfsr
    import lbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lbr_lfsr_ctrl_t       ctrl,
    input  wire logic [DATA_W-1:0]    load_value,
    output logic                      next_bit
);

    logic [DATA_W-1:0] lfsr_reg;
    logic [DATA_W-1:0] lfsr_next;
    logic              feedback;

    assign feedback = lfsr_reg[31] ^ lfsr_reg[6] ^ lfsr_reg[4]
                    ^ lfsr_reg[2] ^ lfsr_reg[1] ^ lfsr_reg[0];

    // low bit of the advanced state
    assign next_bit = lfsr_reg[1];

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (ctrl.load)
        begin
            lfsr_next = load_value;
        end
        else if (ctrl.step)
        begin
            lfsr_next = {feedback, lfsr_reg[DATA_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED_RESET;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lbr_draw_seq.sv]
// ----------------------------------------------------------------------------
// lbr_draw_seq
// Draw sequencer: collects LFSR bits, rejects draws above the bound and
// holds the accepted value in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_draw_seq
    import lbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [DATA_W-1:0]    upper_bound,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [DATA_W-1:0]         drawn_value,
    output logic                      lfsr_step,
    input  wire logic                 lfsr_bit,
    output logic                      idle
);

    lbr_state_t        state_reg,   state_next;
    logic [DATA_W-1:0] bound_reg,   bound_next;
    logic [DATA_W-1:0] mask_reg,    mask_next;
    logic [DATA_W-1:0] draw_reg,    draw_next;
    logic [DATA_W-1:0] result_reg,  result_next;
    logic              out_valid_reg, out_valid_next;
    logic              in_take;
    logic              out_take;
    logic [DATA_W-1:0] draw_shift;
    logic [DATA_W-1:0] mask_shift;

    assign in_stall    = (state_reg != ST_IDLE);
    assign idle        = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign drawn_value = result_reg;
    assign in_take     = in_valid && !in_stall;
    assign out_take    = out_valid_reg && !out_stall;
    assign lfsr_step   = (state_reg == ST_DRAW);
    assign draw_shift  = {draw_reg[DATA_W-2:0], lfsr_bit};
    assign mask_shift  = {1'b0, mask_reg[DATA_W-1:1]};

    always_comb
    begin
        state_next     = state_reg;
        bound_next     = bound_reg;
        mask_next      = mask_reg;
        draw_next      = draw_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    bound_next = upper_bound;
                    mask_next  = upper_bound;
                    draw_next  = '0;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                draw_next = draw_shift;
                mask_next = mask_shift;
                if (mask_shift == '0)
                begin
                    if (draw_shift > bound_reg)
                    begin
                        // rejected: redraw from the current LFSR state
                        draw_next = '0;
                        mask_next = bound_reg;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    result_next    = draw_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg  <= bound_next;
        mask_reg   <= mask_next;
        draw_reg   <= draw_next;
        result_reg <= result_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_take_starts_draw: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_DRAW))
        else $error("accepted transaction did not start a draw");

    // a zero bound draws one bit per attempt with an empty mask
    a_draw_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW && bound_reg != '0) |-> (mask_reg != '0))
        else $error("draw running with empty bit mask");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (draw_reg <= bound_reg))
        else $error("accepted draw exceeds bound");

    a_step_only_drawing: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_step |-> !idle)
        else $error("LFSR stepped while idle");

endmodule

`default_nettype wire
